@@ design/bba_pkg.sv @@
// shared types and constants for the bitmap block allocator
package bba_pkg;

  // bitmap row width, one memory word per row
  localparam int WORD_W = 32;
  localparam int POS_W  = $clog2(WORD_W);

  // fixed field widths of the item ports
  localparam int MODE_W   = 2;
  localparam int ID_W     = 9;
  localparam int STATUS_W = 2;
  localparam int GRANT_W  = 8;
  localparam int COUNT_W  = 9;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd2;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_TAKEN  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // source of the granted block number
  typedef enum logic [1:0] {
    GR_NONE,
    GR_SCAN,
    GR_ID
  } grant_sel_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_UPDATE,
    S_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic       load_op;
    logic       rd_id;
    logic       rd_scan;
    logic       wr_set_scan;
    logic       wr_set_id;
    logic       wr_clr_id;
    logic       res_load;
    status_t    res_status;
    grant_sel_t res_grant;
    logic       out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              id_ok;
    logic              full;
    logic              found;
    logic              scan_more;
    logic              id_bit;
    logic              out_busy;
  } sts_t;

endpackage

@@ design/bba_ctrl.sv @@
// controller state machine for the bitmap block allocator
module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    cmd.res_grant  = GR_NONE;
    in_stall       = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.mode)
          MODE_ALLOC: begin
            if (sts.full) begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              cmd.rd_scan = 1'b1;
              state_nxt   = S_SCAN;
            end
          end
          MODE_REQUEST, MODE_RELEASE: begin
            if (sts.id_ok) begin
              cmd.rd_id = 1'b1;
              state_nxt = S_UPDATE;
            end else begin
              cmd.res_load   = 1'b1;
              cmd.res_status = ST_BAD_ID;
              state_nxt      = S_DONE;
            end
          end
          default: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_BAD_ID;
            state_nxt      = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        // one row checked per cycle, next row read in flight
        if (sts.found) begin
          cmd.wr_set_scan = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_status  = ST_OK;
          cmd.res_grant   = GR_SCAN;
          state_nxt       = S_DONE;
        end else if (sts.scan_more) begin
          cmd.rd_scan = 1'b1;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_FULL;
          state_nxt      = S_DONE;
        end
      end
      S_UPDATE: begin
        cmd.res_load = 1'b1;
        state_nxt    = S_DONE;
        if (sts.mode == MODE_REQUEST) begin
          if (sts.id_bit) begin
            cmd.res_status = ST_TAKEN;
          end else begin
            cmd.wr_set_id  = 1'b1;
            cmd.res_status = ST_OK;
            cmd.res_grant  = GR_ID;
          end
        end else begin
          cmd.wr_clr_id  = sts.id_bit;
          cmd.res_status = ST_OK;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/bba_dp.sv @@
// datapath: bitmap memory, used count, result and output registers
module bba_dp
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS     = 256,
  parameter int RESERVED_START = 0,
  parameter int RESERVED_COUNT = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [ID_W-1:0]     in_block_id,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [GRANT_W-1:0]  out_granted_block,
  output logic [COUNT_W-1:0]  out_used_count,
  output logic [COUNT_W-1:0]  out_free_count
);

  localparam int NUM_ROWS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int SCAN_W   = $clog2(NUM_ROWS + 1);
  localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);
  localparam int RES_END  = (RESERVED_START + RESERVED_COUNT < NUM_BLOCKS) ?
                            (RESERVED_START + RESERVED_COUNT) : NUM_BLOCKS;
  localparam int RES_BEG  = (RESERVED_START < NUM_BLOCKS) ? RESERVED_START : NUM_BLOCKS;
  localparam int RES_USED = RES_END - RES_BEG;

  // reset contents of a row; ids past the end read as used so a scan skips them
  function automatic logic [WORD_W-1:0] rst_row(input logic [ROW_W-1:0] row);
    logic [WORD_W-1:0] w;
    int                id;
    w = '0;
    for (int b = 0; b < WORD_W; b++) begin
      id   = int'(row) * WORD_W + b;
      w[b] = (id >= NUM_BLOCKS) ||
             ((id >= RESERVED_START) && (id < RESERVED_START + RESERVED_COUNT));
    end
    return w;
  endfunction

  logic [WORD_W-1:0]   mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] row_vld_r;
  logic [WORD_W-1:0]   q_r;
  logic [ROW_W-1:0]    rd_row_r;
  logic                rd_vld_r;

  logic [MODE_W-1:0]   op_mode_r;
  logic [ID_W-1:0]     op_id_r;
  logic [SCAN_W-1:0]   scan_cnt_r;
  logic [CNT_W-1:0]    used_total_r;

  status_t             res_status_r;
  logic [GRANT_W-1:0]  res_grant_r;

  logic                out_valid_r;
  logic                out_valid_nxt;
  status_t             out_status_r;
  logic [GRANT_W-1:0]  out_grant_r;
  logic [COUNT_W-1:0]  out_used_r;
  logic [COUNT_W-1:0]  out_free_r;

  logic [ROW_W-1:0]    id_row;
  logic [POS_W-1:0]    id_pos;
  logic [ROW_W-1:0]    rd_addr;
  logic                rd_en;
  logic [WORD_W-1:0]   word;
  logic [POS_W-1:0]    free_pos;
  logic                found;
  logic                wr_en;
  logic [WORD_W-1:0]   wr_word;
  logic [GRANT_W-1:0]  grant_scan;

  // operation capture and scan counter
  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_mode_r  <= in_mode;
      op_id_r    <= in_block_id;
      scan_cnt_r <= '0;
    end else if (cmd.rd_scan) begin
      scan_cnt_r <= scan_cnt_r + 1'b1;
    end
  end

  assign id_row  = ROW_W'(op_id_r >> POS_W);
  assign id_pos  = op_id_r[POS_W-1:0];
  assign rd_addr = cmd.rd_scan ? scan_cnt_r[ROW_W-1:0] : id_row;
  assign rd_en   = cmd.rd_scan || cmd.rd_id;

  // bitmap memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_row_r] <= wr_word;
    end
    if (rd_en) begin
      q_r      <= mem[rd_addr];
      rd_row_r <= rd_addr;
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  // row written flags, unwritten rows read as their reset contents
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_en) begin
      row_vld_r[rd_row_r] <= 1'b1;
    end
  end

  assign word = rd_vld_r ? q_r : rst_row(rd_row_r);

  // lowest clear bit of the row
  always_comb begin
    free_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word[b]) begin
        free_pos = POS_W'(b);
      end
    end
  end

  assign found      = ~&word;
  assign grant_scan = GRANT_W'({rd_row_r, free_pos});

  // row update
  always_comb begin
    wr_word = word;
    if (cmd.wr_set_scan) begin
      wr_word[free_pos] = 1'b1;
    end else if (cmd.wr_set_id) begin
      wr_word[id_pos] = 1'b1;
    end else if (cmd.wr_clr_id) begin
      wr_word[id_pos] = 1'b0;
    end
  end

  assign wr_en = cmd.wr_set_scan || cmd.wr_set_id || cmd.wr_clr_id;

  // running used count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_total_r <= CNT_W'(RES_USED);
    end else if (cmd.wr_set_scan || cmd.wr_set_id) begin
      used_total_r <= used_total_r + 1'b1;
    end else if (cmd.wr_clr_id) begin
      used_total_r <= used_total_r - 1'b1;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      case (cmd.res_grant)
        GR_SCAN: res_grant_r <= grant_scan;
        GR_ID:   res_grant_r <= op_id_r[GRANT_W-1:0];
        default: res_grant_r <= '0;
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_grant_r  <= res_grant_r;
      out_used_r   <= COUNT_W'(used_total_r);
      out_free_r   <= COUNT_W'(CNT_W'(NUM_BLOCKS) - used_total_r);
    end
  end

  // status to controller
  always_comb begin
    sts.mode      = op_mode_r;
    sts.id_ok     = (32'(op_id_r) < NUM_BLOCKS);
    sts.full      = (used_total_r == CNT_W'(NUM_BLOCKS));
    sts.found     = found;
    sts.scan_more = (scan_cnt_r < SCAN_W'(NUM_ROWS));
    sts.id_bit    = word[id_pos];
    sts.out_busy  = out_valid_r && out_stall;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_grant_r;
  assign out_used_count    = out_used_r;
  assign out_free_count    = out_free_r;

endmodule

@@ design/bitmap_block_allocator_top.sv @@
// top level of the bitmap block allocator
//
//   channel | direction | handshake             | fields
//   in      | input     | in_valid / in_stall   | in_mode, in_block_id
//   out     | output    | out_valid / out_stall | out_status, out_granted_block,
//           |           |                       | out_used_count, out_free_count
//
// one item at a time; request and release read the row holding the block id, then update
// it; rejected items go straight to the result; allocate reads the 32-bit bitmap rows one
// by one through the single memory read port until a clear bit turns up, reading at most
// NUM_BLOCKS/32 rows rounded up; allocate on a full map is answered from the used count
// synchronous reset; the map comes up with the reserved run set, no clearing pass
// a stalled result sits in the output register while the next item is taken and worked on
module bitmap_block_allocator_top
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS     = 256,
  parameter int RESERVED_START = 0,
  parameter int RESERVED_COUNT = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [ID_W-1:0]     in_block_id,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [GRANT_W-1:0]  out_granted_block,
  output logic [COUNT_W-1:0]  out_used_count,
  output logic [COUNT_W-1:0]  out_free_count
);

  cmd_t cmd;
  sts_t sts;

  // control
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // bitmap and counters
  bba_dp #(
    .NUM_BLOCKS     (NUM_BLOCKS),
    .RESERVED_START (RESERVED_START),
    .RESERVED_COUNT (RESERVED_COUNT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_block_id       (in_block_id),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_used_count    (out_used_count),
    .out_free_count    (out_free_count)
  );

endmodule
